### rtl/bsqrt_pkg.sv
// Shared types and constants for the bisection square root unit.
`default_nettype none
package bsqrt_pkg;

  localparam int unsigned TolReset = 66;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic within_tol;
    logic collapse;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/bsqrt_dp.sv
// Datapath: search bounds, split squaring, difference test and tolerance register.
`default_nettype none
module bsqrt_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bsqrt_pkg::dp_cmd_t       cmd,
  output bsqrt_pkg::dp_status_t         status,
  input  wire logic                     cfg_we,
  input  wire logic [DATA_WIDTH-1:0]    cfg_data,
  input  wire logic [DATA_WIDTH-1:0]    radicand,
  output logic      [DATA_WIDTH-1:0]    root
);
  import bsqrt_pkg::*;

  localparam int AW = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int H  = (AW + 1) / 2;
  localparam int SW = 4 * H;

  logic [DATA_WIDTH-1:0] tol_r;
  logic [AW-1:0]         lo_r;
  logic [AW-1:0]         hi_r;
  logic [AW-1:0]         guess_r;
  logic [2*H-1:0]        p00_r;
  logic [2*H-1:0]        p01_r;
  logic [2*H-1:0]        p11_r;
  logic [SW-1:0]         sq_r;
  logic [SW-1:0]         target_r;

  logic [AW-1:0]         x_ext;
  logic [AW-1:0]         one;
  logic [AW-1:0]         hi_init;
  logic [2*H-1:0]        g_ext;
  logic [H-1:0]          a0;
  logic [H-1:0]          a1;
  logic [SW-1:0]         tol_s;
  logic                  gt;
  logic [SW-1:0]         diff;
  logic [AW-1:0]         half_lo;
  logic [AW-1:0]         half_hi;
  logic [AW-1:0]         guess_nxt;

  assign x_ext   = AW'(radicand);
  assign one     = AW'(1) << FRAC_BITS;
  assign hi_init = (x_ext >= one) ? x_ext : one;

  assign g_ext = (2*H)'(guess_r);
  assign a0    = g_ext[H-1:0];
  assign a1    = g_ext[2*H-1:H];

  assign tol_s     = SW'(tol_r) << FRAC_BITS;
  assign gt        = sq_r > target_r;
  assign diff      = gt ? (sq_r - target_r) : (target_r - sq_r);
  assign half_lo   = (guess_r - lo_r) >> 1;
  assign half_hi   = (hi_r - guess_r) >> 1;
  assign guess_nxt = gt ? (lo_r + half_lo) : (guess_r + half_hi);

  assign status.within_tol = diff < tol_s;
  assign status.collapse   = guess_nxt == guess_r;
  assign root              = guess_r[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= DATA_WIDTH'(TolReset);
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r     <= '0;
      hi_r     <= hi_init;
      guess_r  <= hi_init >> 1;
      target_r <= SW'(radicand) << FRAC_BITS;
    end
    if (cmd.mul) begin
      p00_r <= (2*H)'(a0) * (2*H)'(a0);
      p01_r <= (2*H)'(a0) * (2*H)'(a1);
      p11_r <= (2*H)'(a1) * (2*H)'(a1);
    end
    if (cmd.sum) begin
      sq_r <= (SW'(p11_r) << (2*H)) + (SW'(p01_r) << (H+1)) + SW'(p00_r);
    end
    if (cmd.update) begin
      if (gt) begin
        hi_r <= guess_r;
      end else begin
        lo_r <= guess_r;
      end
      guess_r <= guess_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/bsqrt_ctrl.sv
// Controller: sequences multiply, sum and evaluate phases and counts steps.
`default_nettype none
module bsqrt_ctrl #(
  parameter int MAX_STEPS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  output bsqrt_pkg::dp_cmd_t         cmd,
  input  wire bsqrt_pkg::dp_status_t status,
  output logic                       out_valid,
  output logic                       out_not_converged
);
  import bsqrt_pkg::*;

  localparam int SC = $clog2(MAX_STEPS + 1);

  typedef enum logic [1:0] {IdleSt, MulSt, SumSt, EvalSt} state_t;

  state_t        state_r, state_nxt;
  logic [SC-1:0] steps_r, steps_nxt;
  logic          valid_r, valid_nxt;
  logic          flag_r, flag_nxt;

  always_comb begin
    state_nxt = state_r;
    steps_nxt = steps_r;
    valid_nxt = 1'b0;
    flag_nxt  = flag_r;
    cmd       = '0;
    case (state_r)
      IdleSt: begin
        if (start) begin
          cmd.load  = 1'b1;
          steps_nxt = '0;
          state_nxt = MulSt;
        end
      end
      MulSt: begin
        cmd.mul   = 1'b1;
        state_nxt = SumSt;
      end
      SumSt: begin
        cmd.sum   = 1'b1;
        state_nxt = EvalSt;
      end
      EvalSt: begin
        if (status.within_tol) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = IdleSt;
        end else if (steps_r == SC'(MAX_STEPS)) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b1;
          state_nxt = IdleSt;
        end else begin
          cmd.update = 1'b1;
          steps_nxt  = SC'(steps_r + 1'b1);
          if (status.collapse) begin
            valid_nxt = 1'b1;
            flag_nxt  = 1'b1;
            state_nxt = IdleSt;
          end else begin
            state_nxt = MulSt;
          end
        end
      end
      default: begin
        state_nxt = IdleSt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IdleSt;
      steps_r <= '0;
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign busy              = state_r != IdleSt;
  assign out_valid         = valid_r;
  assign out_not_converged = flag_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == IdleSt)
    else $error("result strobe outside idle");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe longer than one cycle");
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= SC'(MAX_STEPS))
    else $error("step count beyond limit");
  a_update_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (state_r == EvalSt && !status.within_tol))
    else $error("bound update outside a failed evaluation");
  a_eval_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EvalSt |-> $past(state_r) == SumSt)
    else $error("evaluate without fresh square");
`endif

endmodule
`default_nettype wire

### rtl/bisection_square_root_unit.sv
// Top level of the bisection square root unit: controller plus datapath.
//
//  channel | ports                                  | transfer
//  --------+----------------------------------------+-------------------------
//  input   | start, busy, in_radicand               | start & !busy at clk edge
//  result  | out_valid, out_root, out_not_converged | out_valid, one cycle
//  config  | cfg_valid, cfg_ready, cfg_data         | cfg_valid & cfg_ready
//
//  Each bisection step runs split multiply, partial product sum and
//  evaluate in turn. An item ends when the square is within tolerance,
//  after MAX_STEPS bound updates, or when an update collapses the interval.
//  One item at a time; busy is high from the transfer until the strobe cycle.
//  Reset is synchronous, active low, and loads tolerance 66.
//  The receiver cannot stall: the result is valid for its strobe cycle only.
`default_nettype none
module bisection_square_root_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_STEPS  = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] in_radicand,
  output logic                       out_valid,
  output logic      [DATA_WIDTH-1:0] out_root,
  output logic                       out_not_converged,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [DATA_WIDTH-1:0] cfg_data
);
  import bsqrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bsqrt_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_not_converged (out_not_converged)
  );

  bsqrt_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .radicand (in_radicand),
    .root     (out_root)
  );

endmodule
`default_nettype wire

### verif/bisection_square_root_unit_tb.sv
// Self-checking testbench for the bisection square root unit.
`timescale 1ns / 100ps
module bisection_square_root_unit_tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int STEP_LIMIT = 48;
  localparam logic [DW-1:0] FIX_ONE = DW'(1) << FB;

  typedef logic [2*DW+FB-1:0] wide_t;

  typedef enum logic [1:0] {
    JOB_SQRT,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [DW-1:0] data;
    int unsigned gap_pct;
  } job_t;

  typedef struct {
    logic [DW-1:0] root;
    logic          not_converged;
  } sqrt_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [DW-1:0] in_radicand = '0;
  logic          out_valid;
  logic [DW-1:0] out_root;
  logic          out_not_converged;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [DW-1:0] cfg_data = '0;

  job_t          pending_jobs[$];
  sqrt_result_t  expected_roots[$];
  logic [DW-1:0] tol_setting = bsqrt_pkg::TolReset;
  int unsigned   items_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   errors = 0;

  bisection_square_root_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB),
    .MAX_STEPS (STEP_LIMIT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_radicand      (in_radicand),
    .out_valid        (out_valid),
    .out_root         (out_root),
    .out_not_converged(out_not_converged),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sqrt_result_t bisect_root(input logic [DW-1:0] x,
                                               input logic [DW-1:0] tol);
    logic [DW-1:0] lo_b, hi_b, guess, next_guess;
    wide_t         sq, target, tol_w, diff;
    int            steps;
    logic          done;
    sqrt_result_t  r;
    lo_b = '0;
    hi_b = (x >= FIX_ONE) ? x : FIX_ONE;
    guess = lo_b + ((hi_b - lo_b) >> 1);
    target = wide_t'(x) << FB;
    tol_w = wide_t'(tol) << FB;
    r.not_converged = 1'b0;
    steps = 0;
    done = 1'b0;
    while (!done) begin
      sq = wide_t'(guess) * wide_t'(guess);
      diff = (sq >= target) ? sq - target : target - sq;
      if (diff < tol_w) begin
        done = 1'b1;
      end else if (steps >= STEP_LIMIT) begin
        r.not_converged = 1'b1;
        done = 1'b1;
      end else begin
        if (sq > target) hi_b = guess;
        else lo_b = guess;
        next_guess = lo_b + ((hi_b - lo_b) >> 1);
        steps++;
        if (next_guess == guess) begin
          r.not_converged = 1'b1;
          done = 1'b1;
        end else begin
          guess = next_guess;
        end
      end
    end
    r.root = guess;
    return r;
  endfunction

  function automatic logic [DW-1:0] pick_radicand();
    logic [DW-1:0] k;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'hFFFF);
      1: begin
        k = $urandom_range(0, 16'hFFFF);
        return k * k;
      end
      2: return DW'($urandom) >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return DW'(1);
          2: return FIX_ONE - 1;
          3: return FIX_ONE;
          4: return FIX_ONE + 1;
          default: return '1;
        endcase
      end
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic add_job(input job_kind_t kind, input logic [DW-1:0] data,
                         input int unsigned gap_pct);
    job_t j;
    j.kind = kind;
    j.data = data;
    j.gap_pct = gap_pct;
    pending_jobs.push_back(j);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : driver
    logic        start_next;
    logic        cfg_next;
    int unsigned sent_now;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      items_sent <= 0;
      tol_setting = bsqrt_pkg::TolReset;
    end else begin
      start_next = start;
      cfg_next = cfg_valid;
      sent_now = items_sent;
      if (start && !busy) begin
        expected_roots.push_back(bisect_root(in_radicand, tol_setting));
        void'(pending_jobs.pop_front());
        sent_now++;
        start_next = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        tol_setting = cfg_data;
        void'(pending_jobs.pop_front());
        cfg_next = 1'b0;
      end
      if (!start_next && !cfg_next && pending_jobs.size() != 0) begin
        case (pending_jobs[0].kind)
          JOB_SQRT: begin
            if ($urandom_range(0, 99) >= pending_jobs[0].gap_pct) begin
              start_next = 1'b1;
              in_radicand <= pending_jobs[0].data;
            end
          end
          JOB_CFG: begin
            if (sent_now == results_seen) begin
              cfg_next = 1'b1;
              cfg_data <= pending_jobs[0].data;
            end
          end
          default: begin
            if (sent_now == results_seen) void'(pending_jobs.pop_front());
          end
        endcase
      end
      start <= start_next;
      cfg_valid <= cfg_next;
      items_sent <= sent_now;
    end
  end

  always @(posedge clk) begin : monitor
    sqrt_result_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result root=%h", out_root));
      end else begin
        want = expected_roots.pop_front();
        if (out_root !== want.root)
          report_mismatch($sformatf("root %h, want %h", out_root, want.root));
        if (out_not_converged !== want.not_converged)
          report_mismatch($sformatf("not_converged %b, want %b", out_not_converged,
                                    want.not_converged));
      end
    end
  end

  initial begin
    #(64'd30_000_000);
    $display("bisection_square_root_unit_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [DW-1:0] tol_a, tol_b;
    int unsigned   gap;
    add_job(JOB_CFG, bsqrt_pkg::TolReset, 0);
    add_job(JOB_SQRT, 32'h0000_0000, 0);
    add_job(JOB_SQRT, 32'h0000_0001, 0);
    add_job(JOB_SQRT, 32'h0000_FFFF, 0);
    add_job(JOB_SQRT, 32'h0001_0000, 0);
    add_job(JOB_SQRT, 32'h0001_0001, 0);
    add_job(JOB_SQRT, 32'h0000_4000, 0);
    add_job(JOB_SQRT, 32'h0004_0000, 0);
    add_job(JOB_SQRT, 32'h0009_0000, 0);
    add_job(JOB_SQRT, 32'h0002_0000, 0);
    add_job(JOB_SQRT, 32'h7FFF_FFFF, 0);
    add_job(JOB_SQRT, 32'h8000_0000, 0);
    add_job(JOB_SQRT, 32'hFFFF_FFFF, 0);
    add_job(JOB_SQRT, 32'hAAAA_AAAA, 0);
    add_job(JOB_SQRT, 32'h5555_5555, 0);
    add_job(JOB_CFG, '0, 0);
    add_job(JOB_SQRT, 32'h0000_0000, 0);
    add_job(JOB_SQRT, 32'h0004_0000, 0);
    add_job(JOB_SQRT, 32'h0002_0000, 0);
    add_job(JOB_SQRT, 32'hFFFF_FFFF, 0);
    add_job(JOB_CFG, '1, 0);
    add_job(JOB_SQRT, 32'h0000_0000, 0);
    add_job(JOB_SQRT, 32'h0002_0000, 0);
    add_job(JOB_SQRT, 32'hFFFF_FFFF, 0);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          gap = 0;
          tol_a = bsqrt_pkg::TolReset;
          tol_b = '0;
        end
        1: begin
          gap = 81;
          tol_a = DW'($urandom) >> $urandom_range(8, 31);
          tol_b = DW'(1);
        end
        2: begin
          gap = 0;
          tol_a = '1;
          tol_b = $urandom_range(0, 1000);
        end
        default: begin
          gap = 33;
          tol_a = bsqrt_pkg::TolReset;
          tol_b = DW'($urandom);
        end
      endcase
      add_job(JOB_CFG, tol_a, 0);
      for (int i = 0; i < 360; i++) begin
        if (i == 180) add_job(JOB_CFG, tol_b, 0);
        if (i == 90 && p == 1) add_job(JOB_DRAIN, '0, 0);
        add_job(JOB_SQRT, pick_radicand(), gap);
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_jobs.size() != 0 || items_sent != results_seen) @(negedge clk);
    repeat (160) @(negedge clk);
    if (expected_roots.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_roots.size()));
    if (errors == 0) begin
      $display("bisection_square_root_unit_tb: done, clean");
    end else begin
      $display("bisection_square_root_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
